/* hw/rtl/mtfq_pkg.sv */
// ----------------------------------------------------------------------------
// mtfq_pkg
// Shared types, widths and helpers of the move-to-front rotating queue.
// ----------------------------------------------------------------------------
package mtfq_pkg;

  localparam int unsigned Depth   = 1024;
  localparam int unsigned AddrW   = $clog2(Depth);
  localparam int unsigned LenW    = $clog2(Depth + 1);
  localparam int unsigned IdW     = 32;
  localparam int unsigned CfgIdxW = 8;
  localparam int unsigned CfgW    = 32;

  localparam logic [CfgIdxW-1:0] CfgPopulation = CfgIdxW'(0);
  localparam logic [CfgIdxW-1:0] CfgPlanned    = CfgIdxW'(1);

  localparam logic FuncServe    = 1'b0;
  localparam logic FuncExpedite = 1'b1;

  localparam logic [LenW-1:0]  DepthLen  = LenW'(Depth);
  localparam logic [AddrW-1:0] LastAddr  = AddrW'(Depth - 1);
  localparam logic [CfgW-1:0]  DepthCfg  = CfgW'(Depth);

  typedef enum logic [2:0] {
    ST_FILL,
    ST_IDLE,
    ST_SERVE,
    ST_SEARCH,
    ST_SHIFT,
    ST_FRONT
  } state_e;

  typedef struct packed {
    logic            reload;
    logic            drop_mode;
    logic [LenW-1:0] load_len;
  } cfg_status_t;

  // circular address: base plus offset, offset at most Depth
  function automatic logic [AddrW-1:0] wrap_add(logic [AddrW-1:0] base,
                                                logic [LenW-1:0] off);
    logic [LenW:0] sum;
    sum = (LenW+1)'(base) + (LenW+1)'(off);
    if (sum >= (LenW+1)'(Depth)) begin
      sum = sum - (LenW+1)'(Depth);
    end
    return sum[AddrW-1:0];
  endfunction

  function automatic logic [AddrW-1:0] wrap_dec(logic [AddrW-1:0] base);
    logic [AddrW-1:0] res;
    if (base == '0) begin
      res = LastAddr;
    end else begin
      res = base - AddrW'(1);
    end
    return res;
  endfunction

endpackage

/* hw/rtl/mtfq_if.sv */
// ----------------------------------------------------------------------------
// mtfq_if
// Word channels of the move-to-front rotating queue: command, result, config.
// ----------------------------------------------------------------------------
interface mtfq_in_if;
  logic                     valid;
  logic                     ready;
  logic                     func;
  logic [mtfq_pkg::IdW-1:0] id;

  modport source (output valid, output func, output id, input ready);
  modport sink   (input valid, input func, input id, output ready);
endinterface

interface mtfq_out_if;
  logic                     valid;
  logic                     ready;
  logic [mtfq_pkg::IdW-1:0] served_id;

  modport source (output valid, output served_id, input ready);
  modport sink   (input valid, input served_id, output ready);
endinterface

interface mtfq_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [mtfq_pkg::CfgIdxW-1:0] index;
  logic [mtfq_pkg::CfgW-1:0]    data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

/* hw/rtl/mtfq_cfg_regs.sv */
// ----------------------------------------------------------------------------
// mtfq_cfg_regs
// Population and planned-command registers; derives load length and mode.
// ----------------------------------------------------------------------------
module mtfq_cfg_regs (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  mtfq_cfg_if.sink              cfg_i,
  output mtfq_pkg::cfg_status_t status_o
);

  logic [mtfq_pkg::CfgW-1:0] pop_q, pop_d;
  logic [mtfq_pkg::CfgW-1:0] cmd_q, cmd_d;
  logic [mtfq_pkg::CfgW-1:0] min_pc;
  logic                      wr_acc;

  assign cfg_i.ready = 1'b1;
  assign wr_acc      = cfg_i.valid && cfg_i.ready;

  always_comb begin
    pop_d           = pop_q;
    cmd_d           = cmd_q;
    status_o.reload = 1'b0;
    if (wr_acc) begin
      priority if (cfg_i.index == mtfq_pkg::CfgPopulation) begin
        pop_d           = cfg_i.data;
        status_o.reload = 1'b1;
      end else if (cfg_i.index == mtfq_pkg::CfgPlanned) begin
        cmd_d           = cfg_i.data;
        status_o.reload = 1'b1;
      end else begin
        status_o.reload = 1'b0;
      end
    end

    min_pc = (cmd_q < pop_q) ? cmd_q : pop_q;
    if (min_pc > mtfq_pkg::DepthCfg) begin
      status_o.load_len = mtfq_pkg::DepthLen;
    end else begin
      status_o.load_len = min_pc[mtfq_pkg::LenW-1:0];
    end
    status_o.drop_mode = cmd_q < pop_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pop_q <= mtfq_pkg::CfgW'(1);
      cmd_q <= mtfq_pkg::CfgW'(1);
    end else begin
      pop_q <= pop_d;
      cmd_q <= cmd_d;
    end
  end

endmodule

/* hw/rtl/move_to_front_rotating_queue_unit.sv */
// ----------------------------------------------------------------------------
// move_to_front_rotating_queue_unit
// Move-to-front id list held as a circular buffer in one synchronous RAM.
// ----------------------------------------------------------------------------
// Serve: the head entry is read while idle and the result word is registered in
//   ST_SERVE; no command word is taken meanwhile, and a held result word stalls
//   the next serve until it is taken.
// Expedite of an id at list position p: pipelined search of one entry per cycle,
//   then one RAM read/write per shifted entry (the RAM has one read and one write
//   port); a missing id is written in front of the list after the full search.
// Reset and each population or planned write load ids 1..L, one RAM write per
//   cycle (L = min(population, planned_commands, 1024)); commands wait meanwhile.
module move_to_front_rotating_queue_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  mtfq_in_if.sink     in_i,
  mtfq_out_if.source  out_o,
  mtfq_cfg_if.sink    cfg_i
);

  mtfq_pkg::cfg_status_t cfg;

  mtfq_cfg_regs u_cfg_regs (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg_i),
    .status_o (cfg)
  );

  mtfq_pkg::state_e state_q, state_d;

  logic [mtfq_pkg::AddrW-1:0] head_q, head_d;
  logic [mtfq_pkg::LenW-1:0]  len_q, len_d;
  logic [mtfq_pkg::LenW-1:0]  fill_q, fill_d;
  logic [mtfq_pkg::LenW-1:0]  scan_q, scan_d;
  logic [mtfq_pkg::LenW-1:0]  chk_pos_q, chk_pos_d;
  logic [mtfq_pkg::LenW-1:0]  pos_q, pos_d;
  logic                       chk_q, chk_d;
  logic [mtfq_pkg::IdW-1:0]   id_q, id_d;
  logic                       out_valid_q, out_valid_d;
  logic [mtfq_pkg::IdW-1:0]   out_data_q, out_data_d;

  logic [mtfq_pkg::IdW-1:0]   mem [mtfq_pkg::Depth];
  logic                       mem_we;
  logic [mtfq_pkg::AddrW-1:0] mem_waddr;
  logic [mtfq_pkg::IdW-1:0]   mem_wdata;
  logic [mtfq_pkg::AddrW-1:0] mem_raddr;
  logic [mtfq_pkg::IdW-1:0]   rd_data_q;

  logic in_acc;
  logic scan_hit;

  assign in_i.ready      = (state_q == mtfq_pkg::ST_IDLE);
  assign in_acc          = in_i.valid && in_i.ready;
  assign out_o.valid     = out_valid_q;
  assign out_o.served_id = out_data_q;

  always_comb begin
    state_d     = state_q;
    head_d      = head_q;
    len_d       = len_q;
    fill_d      = fill_q;
    scan_d      = scan_q;
    chk_pos_d   = chk_pos_q;
    pos_d       = pos_q;
    chk_d       = chk_q;
    id_d        = id_q;
    out_valid_d = out_valid_q && !out_o.ready;
    out_data_d  = out_data_q;
    mem_we      = 1'b0;
    mem_waddr   = head_q;
    mem_wdata   = id_q;
    mem_raddr   = head_q;
    scan_hit    = scan_q < len_q;

    unique case (state_q)
      mtfq_pkg::ST_FILL: begin
        if (fill_q < cfg.load_len) begin
          mem_we    = 1'b1;
          mem_waddr = fill_q[mtfq_pkg::AddrW-1:0];
          mem_wdata = mtfq_pkg::IdW'(fill_q) + mtfq_pkg::IdW'(1);
          fill_d    = fill_q + mtfq_pkg::LenW'(1);
        end else begin
          len_d   = cfg.load_len;
          head_d  = '0;
          state_d = mtfq_pkg::ST_IDLE;
        end
      end

      mtfq_pkg::ST_IDLE: begin
        if (in_acc) begin
          id_d = in_i.id;
          if (in_i.func == mtfq_pkg::FuncExpedite) begin
            scan_d  = '0;
            chk_d   = 1'b0;
            state_d = mtfq_pkg::ST_SEARCH;
          end else if (len_q != '0) begin
            state_d = mtfq_pkg::ST_SERVE;
          end
        end
      end

      mtfq_pkg::ST_SERVE: begin
        if (!out_valid_q || out_o.ready) begin
          out_valid_d = 1'b1;
          out_data_d  = rd_data_q;
          head_d      = mtfq_pkg::wrap_add(head_q, mtfq_pkg::LenW'(1));
          if (cfg.drop_mode) begin
            len_d = len_q - mtfq_pkg::LenW'(1);
          end else begin
            mem_we    = 1'b1;
            mem_waddr = mtfq_pkg::wrap_add(head_q, len_q);
            mem_wdata = rd_data_q;
          end
          state_d = mtfq_pkg::ST_IDLE;
        end
      end

      mtfq_pkg::ST_SEARCH: begin
        mem_raddr = mtfq_pkg::wrap_add(head_q, scan_q);
        chk_d     = scan_hit;
        chk_pos_d = scan_q;
        if (scan_hit) begin
          scan_d = scan_q + mtfq_pkg::LenW'(1);
        end
        if (chk_q && (rd_data_q == id_q)) begin
          chk_d = 1'b0;
          if (chk_pos_q == '0) begin
            state_d = mtfq_pkg::ST_FRONT;
          end else begin
            mem_raddr = mtfq_pkg::wrap_add(head_q, chk_pos_q - mtfq_pkg::LenW'(1));
            pos_d     = chk_pos_q - mtfq_pkg::LenW'(1);
            state_d   = mtfq_pkg::ST_SHIFT;
          end
        end else if (!chk_q && !scan_hit) begin
          head_d    = mtfq_pkg::wrap_dec(head_q);
          mem_we    = 1'b1;
          mem_waddr = mtfq_pkg::wrap_dec(head_q);
          mem_wdata = id_q;
          if (len_q != mtfq_pkg::DepthLen) begin
            len_d = len_q + mtfq_pkg::LenW'(1);
          end
          state_d = mtfq_pkg::ST_IDLE;
        end
      end

      mtfq_pkg::ST_SHIFT: begin
        mem_we    = 1'b1;
        mem_waddr = mtfq_pkg::wrap_add(head_q, pos_q + mtfq_pkg::LenW'(1));
        mem_wdata = rd_data_q;
        if (pos_q == '0) begin
          state_d = mtfq_pkg::ST_FRONT;
        end else begin
          mem_raddr = mtfq_pkg::wrap_add(head_q, pos_q - mtfq_pkg::LenW'(1));
          pos_d     = pos_q - mtfq_pkg::LenW'(1);
        end
      end

      mtfq_pkg::ST_FRONT: begin
        mem_we    = 1'b1;
        mem_waddr = head_q;
        mem_wdata = id_q;
        state_d   = mtfq_pkg::ST_IDLE;
      end

      default: begin
        state_d = mtfq_pkg::ST_FILL;
        fill_d  = '0;
      end
    endcase

    if (cfg.reload) begin
      state_d = mtfq_pkg::ST_FILL;
      fill_d  = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= mtfq_pkg::ST_FILL;
      head_q      <= '0;
      len_q       <= '0;
      fill_q      <= '0;
      scan_q      <= '0;
      chk_pos_q   <= '0;
      pos_q       <= '0;
      chk_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      head_q      <= head_d;
      len_q       <= len_d;
      fill_q      <= fill_d;
      scan_q      <= scan_d;
      chk_pos_q   <= chk_pos_d;
      pos_q       <= pos_d;
      chk_q       <= chk_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    id_q       <= id_d;
    out_data_q <= out_data_d;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_data_q <= mem[mem_raddr];
  end

endmodule
